>>> sv/integer_to_text_radix_assert.svh
// assertion macros used by the integer to text converter checker
`ifndef INTEGER_TO_TEXT_RADIX_ASSERT_SVH
`define INTEGER_TO_TEXT_RADIX_ASSERT_SVH

// same-cycle implication, idle while reset is asserted
`define ITR_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, idle while reset is asserted
`define ITR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/itr_pkg.sv
// shared types, constants and helpers of the integer to text converter
package itr_pkg;

    localparam int VALUE_BITS_DEF = 32;
    localparam int MAX_TEXT       = 64;

    localparam int RADIX_W    = 6;
    localparam int WIDTH_W    = 6;
    localparam int CHAR_W     = 8;
    localparam int ROOM_W     = 8;
    localparam int TEXT_LEN_W = 7;
    localparam int OUT_DATA_W = 16;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 8;

    localparam logic [CFG_INDEX_W-1:0] CFG_RADIX     = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MIN_WIDTH = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_PAD_CHAR  = 2'd2;

    localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
    localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;

    localparam logic [CHAR_W-1:0] CHAR_NUL    = 8'h00;
    localparam logic [CHAR_W-1:0] CHAR_SPACE  = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_MINUS  = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_ZERO   = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_UPPER  = 8'h41;
    localparam logic [CHAR_W-1:0] DECIMAL_TOP = 8'd10;

    typedef struct packed {
        logic load;
        logic div_step;
        logic digit;
        logic size;
        logic emit;
    } itr_cmd_t;

    typedef struct packed {
        logic div_last;
        logic quot_zero;
        logic emit_last;
        logic out_free;
    } itr_status_t;

    // digit value 0..35 to uppercase ascii
    function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d);
        logic [CHAR_W-1:0] dx;
        dx = {{(CHAR_W-RADIX_W){1'b0}}, d};
        if (dx < DECIMAL_TOP) begin
            return CHAR_ZERO + dx;
        end
        return CHAR_UPPER + dx - DECIMAL_TOP;
    endfunction

endpackage

>>> sv/itr_ctrl.sv
// controller state machine of the integer to text converter
module itr_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  itr_pkg::itr_status_t status,
    output itr_pkg::itr_cmd_t    cmd
);
    import itr_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_DIGIT,
        ST_SIZE,
        ST_EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (status.div_last) begin
                    state_next = ST_DIGIT;
                end
            end
            ST_DIGIT: begin
                cmd.digit  = 1'b1;
                state_next = status.quot_zero ? ST_SIZE : ST_DIV;
            end
            ST_SIZE: begin
                cmd.size   = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (status.out_free) begin
                    cmd.emit = 1'b1;
                    if (status.emit_last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

>>> sv/itr_datapath.sv
// datapath of the integer to text converter: registers, divider, digit stack, output stage
module itr_datapath #(
    parameter int VALUE_BITS = itr_pkg::VALUE_BITS_DEF
) (
    input  logic                                             aclk,
    input  logic                                             aresetn,
    input  logic [((VALUE_BITS+itr_pkg::ROOM_W+7)/8)*8-1:0]  s_tdata,
    output logic                                             m_tvalid,
    input  logic                                             m_tready,
    output logic [itr_pkg::OUT_DATA_W-1:0]                   m_tdata,
    output logic                                             m_tuser,
    output logic                                             m_tlast,
    input  logic                                             cfg_valid,
    output logic                                             cfg_ready,
    input  logic [itr_pkg::CFG_INDEX_W-1:0]                  cfg_index,
    input  logic [itr_pkg::CFG_DATA_W-1:0]                   cfg_data,
    input  itr_pkg::itr_cmd_t                                cmd,
    output itr_pkg::itr_status_t                             status
);
    import itr_pkg::*;

    localparam int BIT_CNT_W = $clog2(VALUE_BITS);
    localparam int NDIG_W    = $clog2(VALUE_BITS + 1);
    localparam int LEN_MAX   = ((VALUE_BITS > 63) ? VALUE_BITS : 63) + 1;
    localparam int LEN_W     = $clog2(LEN_MAX + 1);
    localparam int CMP_W     = (LEN_W > ROOM_W) ? LEN_W : ROOM_W;
    localparam bit CAN_LONG  = (MAX_TEXT < LEN_MAX);

    logic [RADIX_W-1:0] radix_reg;
    logic [WIDTH_W-1:0] min_width_reg;
    logic [CHAR_W-1:0]  pad_char_reg;

    logic [RADIX_W-1:0]    base_reg;
    logic                  neg_reg;
    logic [ROOM_W-1:0]     room_reg;
    logic [VALUE_BITS-1:0] quot_reg;
    logic [RADIX_W-1:0]    rem_reg;
    logic [BIT_CNT_W-1:0]  bit_cnt_reg;
    logic [NDIG_W-1:0]     ndig_reg;
    logic [RADIX_W-1:0]    stack_reg [VALUE_BITS];
    logic [LEN_W-1:0]      len_reg;
    logic [LEN_W-1:0]      left_reg;
    logic                  lo_reg;

    logic                  out_valid_reg;
    logic [CHAR_W-1:0]     out_ch_reg;
    logic [TEXT_LEN_W-1:0] out_len_reg;
    logic                  out_lo_reg;
    logic                  out_last_reg;

    logic [VALUE_BITS-1:0] value_in;
    logic [ROOM_W-1:0]     room_in;
    logic                  neg_in;
    logic [VALUE_BITS-1:0] mag_in;
    logic [RADIX_W-1:0]    base_in;
    logic [RADIX_W:0]      trial;
    logic                  trial_ge;
    logic [RADIX_W-1:0]    rem_step;
    logic [LEN_W-1:0]      len_digits;
    logic [LEN_W-1:0]      len_field;
    logic [LEN_W-1:0]      len_calc;
    logic                  too_long;
    logic                  too_small;
    logic                  digit_sel;
    logic                  first_pos;
    logic                  emit_last;
    logic [CHAR_W-1:0]     pad_eff;
    logic [CHAR_W-1:0]     ch_next;

    assign value_in = s_tdata[VALUE_BITS-1:0];
    assign room_in  = s_tdata[VALUE_BITS+ROOM_W-1:VALUE_BITS];
    assign neg_in   = value_in[VALUE_BITS-1];
    assign mag_in   = neg_in ? ((~value_in) + {{(VALUE_BITS-1){1'b0}}, 1'b1}) : value_in;

    always_comb begin
        if (radix_reg < RADIX_MIN) begin
            base_in = RADIX_MIN;
        end else if (radix_reg > RADIX_MAX) begin
            base_in = RADIX_MAX;
        end else begin
            base_in = radix_reg;
        end
    end

    // restoring division, one quotient bit a cycle
    assign trial    = {rem_reg, quot_reg[VALUE_BITS-1]};
    assign trial_ge = (trial >= {1'b0, base_reg});
    assign rem_step = trial_ge ? RADIX_W'(trial - {1'b0, base_reg}) : trial[RADIX_W-1:0];

    assign len_digits = LEN_W'(ndig_reg) + LEN_W'(neg_reg);
    assign len_field  = LEN_W'(min_width_reg) + LEN_W'(neg_reg);
    assign len_calc   = (len_field > len_digits) ? len_field : len_digits;
    assign too_long   = CAN_LONG && (len_calc > LEN_W'(MAX_TEXT));
    assign too_small  = (CMP_W'(room_reg) <= CMP_W'(len_calc));

    assign pad_eff   = (pad_char_reg == CHAR_NUL) ? CHAR_SPACE : pad_char_reg;
    assign digit_sel = (left_reg <= LEN_W'(ndig_reg));
    assign first_pos = (left_reg == len_reg);
    assign emit_last = lo_reg || (left_reg == LEN_W'(1));

    always_comb begin
        if (lo_reg) begin
            ch_next = CHAR_NUL;
        end else if (digit_sel) begin
            ch_next = digit_char(stack_reg[0]);
        end else if (neg_reg && first_pos) begin
            ch_next = CHAR_MINUS;
        end else begin
            ch_next = pad_eff;
        end
    end

    assign status.div_last  = (bit_cnt_reg == BIT_CNT_W'(VALUE_BITS - 1));
    assign status.quot_zero = (quot_reg == '0);
    assign status.emit_last = emit_last;
    assign status.out_free  = !out_valid_reg || m_tready;

    assign cfg_ready = 1'b1;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_DATA_W-TEXT_LEN_W-CHAR_W){1'b0}}, out_len_reg, out_ch_reg};
    assign m_tuser  = out_lo_reg;
    assign m_tlast  = out_last_reg;

    // control state and configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radix_reg     <= RADIX_RESET;
            min_width_reg <= '0;
            pad_char_reg  <= CHAR_NUL;
            out_valid_reg <= 1'b0;
            bit_cnt_reg   <= '0;
            ndig_reg      <= '0;
        end else begin
            if (cfg_valid) begin
                unique case (cfg_index)
                    CFG_RADIX:     radix_reg     <= cfg_data[RADIX_W-1:0];
                    CFG_MIN_WIDTH: min_width_reg <= cfg_data[WIDTH_W-1:0];
                    CFG_PAD_CHAR:  pad_char_reg  <= cfg_data;
                    default: ;
                endcase
            end
            if (cmd.emit) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            if (cmd.load || cmd.digit) begin
                bit_cnt_reg <= '0;
            end else if (cmd.div_step) begin
                bit_cnt_reg <= bit_cnt_reg + BIT_CNT_W'(1);
            end
            if (cmd.load) begin
                ndig_reg <= '0;
            end else if (cmd.digit) begin
                ndig_reg <= ndig_reg + NDIG_W'(1);
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            base_reg <= base_in;
            neg_reg  <= neg_in;
            room_reg <= room_in;
            quot_reg <= mag_in;
            rem_reg  <= '0;
        end else if (cmd.div_step) begin
            rem_reg  <= rem_step;
            quot_reg <= {quot_reg[VALUE_BITS-2:0], trial_ge};
        end else if (cmd.digit) begin
            rem_reg <= '0;
        end

        if (cmd.digit) begin
            stack_reg[0] <= rem_reg;
            for (int i = 1; i < VALUE_BITS; i++) begin
                stack_reg[i] <= stack_reg[i-1];
            end
        end else if (cmd.emit && !lo_reg && digit_sel) begin
            for (int i = 0; i < VALUE_BITS - 1; i++) begin
                stack_reg[i] <= stack_reg[i+1];
            end
        end

        if (cmd.size) begin
            len_reg  <= len_calc;
            left_reg <= len_calc;
            lo_reg   <= too_long || too_small;
        end else if (cmd.emit) begin
            left_reg <= left_reg - LEN_W'(1);
        end

        if (cmd.emit) begin
            out_ch_reg   <= ch_next;
            out_len_reg  <= TEXT_LEN_W'(len_reg);
            out_lo_reg   <= lo_reg;
            out_last_reg <= emit_last;
        end
    end

endmodule

>>> sv/integer_to_text_radix.sv
// top level of the integer to text converter
//
//   channel  direction  contents
//   s_       in         value, room
//   m_       out        ch, text_len, length_only, last
//   cfg_     in         register index and write data
//
// an item is accepted, each digit is formed by a full pass of the bit-serial divider,
// the text length is sized, and one character is emitted per cycle while m_ is not stalled.
// reset is synchronous and active low; registers return to base 10, no width, space pad.
// a stalled m_ side holds the character stage; s_ accepts again once the last
// character is in the output register.
module integer_to_text_radix #(
    parameter int VALUE_BITS = itr_pkg::VALUE_BITS_DEF
) (
    input  logic                                             aclk,
    input  logic                                             aresetn,
    input  logic                                             s_tvalid,
    output logic                                             s_tready,
    // value, room
    input  logic [((VALUE_BITS+itr_pkg::ROOM_W+7)/8)*8-1:0]  s_tdata,
    output logic                                             m_tvalid,
    input  logic                                             m_tready,
    // ch, text_len
    output logic [itr_pkg::OUT_DATA_W-1:0]                   m_tdata,
    // length_only
    output logic                                             m_tuser,
    output logic                                             m_tlast,
    input  logic                                             cfg_valid,
    output logic                                             cfg_ready,
    input  logic [itr_pkg::CFG_INDEX_W-1:0]                  cfg_index,
    input  logic [itr_pkg::CFG_DATA_W-1:0]                   cfg_data
);
    import itr_pkg::*;

    itr_cmd_t    cmd;
    itr_status_t status;

    itr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    itr_datapath #(
        .VALUE_BITS (VALUE_BITS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

>>> sv/itr_checker.sv
// port-level checker of the integer to text converter, bound to the top level
`include "integer_to_text_radix_assert.svh"

module itr_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [itr_pkg::OUT_DATA_W-1:0] m_tdata,
    input logic                           m_tuser,
    input logic                           m_tlast
);

    `ITR_ASSERT_NEXT(a_in_single, s_tvalid && s_tready, !s_tready, "input accepted twice in a row")
    `ITR_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid, "stalled transfer dropped")
    `ITR_ASSERT_NEXT(a_out_stable, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tlast), "stalled transfer changed")
    `ITR_ASSERT_SAME(a_len_only_single, m_tvalid && m_tuser, m_tlast && (m_tdata[7:0] == 8'd0), "length-only transfer not single")
    `ITR_ASSERT_SAME(a_len_nonzero, m_tvalid, m_tdata[14:8] != 7'd0, "zero text length")

endmodule

bind integer_to_text_radix itr_checker u_checker (.*);

>>> verif/tb_top.sv
// self-checking testbench of the integer to text converter, covering radix, field width and padding
module tb_top;
    import itr_pkg::*;

    localparam int S_DATA_W = ((VALUE_BITS_DEF + ROOM_W + 7) / 8) * 8;
    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED = 2'd3;
    localparam int HOLD_CYCLES = 2500;
    localparam int TAIL_CYCLES = 1200;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [CHAR_W-1:0]     ch;
        logic [TEXT_LEN_W-1:0] text_len;
        logic                  length_only;
        logic                  last;
    } text_beat_t;

    logic                   aclk;
    logic                   aresetn = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [S_DATA_W-1:0]    s_tdata = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_DATA_W-1:0]  m_tdata;
    logic                   m_tuser;
    logic                   m_tlast;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    // register copies kept by the predictor
    logic [RADIX_W-1:0] radix_setting = RADIX_RESET;
    logic [WIDTH_W-1:0] width_setting = '0;
    logic [CHAR_W-1:0]  pad_setting = CHAR_NUL;

    text_beat_t expected_text[$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_left = 0;
    int error_count = 0;
    int items_sent = 0;
    int beats_checked = 0;
    int length_only_seen = 0;
    int config_writes = 0;

    integer_to_text_radix u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        #20_000_000;
        $display("integer_to_text_radix regression: fail");
        $finish;
    end

    function automatic int unsigned effective_base();
        if (radix_setting < RADIX_MIN) begin
            return RADIX_MIN;
        end
        if (radix_setting > RADIX_MAX) begin
            return RADIX_MAX;
        end
        return radix_setting;
    endfunction

    function automatic int unsigned text_length(input logic [31:0] value);
        logic [31:0] mag;
        int unsigned base;
        int unsigned ndig;
        int unsigned len;
        int unsigned width;
        base = effective_base();
        mag = value[31] ? (~value + 32'd1) : value;
        ndig = 1;
        while (mag >= base) begin
            mag = mag / base;
            ndig++;
        end
        len = ndig + value[31];
        width = width_setting + value[31];
        return (width > len) ? width : len;
    endfunction

    function automatic void predict_text(input logic [31:0] value, input logic [ROOM_W-1:0] room);
        logic [31:0] mag;
        int unsigned base;
        int unsigned len;
        int unsigned pos;
        int unsigned k;
        logic [CHAR_W-1:0] row [0:MAX_TEXT-1];
        logic [CHAR_W-1:0] pad;
        logic [RADIX_W-1:0] d;
        text_beat_t beat;
        base = effective_base();
        len = text_length(value);
        if (room < len + 1 || len > MAX_TEXT) begin
            beat.ch = CHAR_NUL;
            beat.text_len = len[TEXT_LEN_W-1:0];
            beat.length_only = 1'b1;
            beat.last = 1'b1;
            expected_text.push_back(beat);
            return;
        end
        pad = (pad_setting == CHAR_NUL) ? CHAR_SPACE : pad_setting;
        for (k = 0; k < len; k++) begin
            row[k] = pad;
        end
        mag = value[31] ? (~value + 32'd1) : value;
        pos = len;
        do begin
            pos--;
            d = RADIX_W'(mag % base);
            row[pos] = (d < 10) ? CHAR_ZERO + d : CHAR_UPPER + d - 8'd10;
            mag = mag / base;
        end while (mag != 0 && pos > 0);
        if (value[31]) begin
            row[0] = CHAR_MINUS;
        end
        for (k = 0; k < len; k++) begin
            beat.ch = row[k];
            beat.text_len = len[TEXT_LEN_W-1:0];
            beat.length_only = 1'b0;
            beat.last = (k + 1 == len);
            expected_text.push_back(beat);
        end
    endfunction

    function automatic void check_beat();
        text_beat_t want;
        if (expected_text.size() == 0) begin
            error_count++;
            if (error_count <= MAX_REPORTS) begin
                $display("unexpected transfer at %0t: tdata=%h tuser=%b tlast=%b",
                         $time, m_tdata, m_tuser, m_tlast);
            end
            return;
        end
        want = expected_text.pop_front();
        beats_checked++;
        if (want.length_only) begin
            length_only_seen++;
        end
        if (m_tdata[CHAR_W-1:0] !== want.ch
                || m_tdata[CHAR_W+TEXT_LEN_W-1:CHAR_W] !== want.text_len
                || m_tdata[OUT_DATA_W-1] !== 1'b0
                || m_tuser !== want.length_only || m_tlast !== want.last) begin
            error_count++;
            if (error_count <= MAX_REPORTS) begin
                $display("mismatch at %0t: expected ch=%h len=%0d len_only=%b last=%b",
                         $time, want.ch, want.text_len, want.length_only, want.last);
                $display("    actual ch=%h len=%0d pad=%b len_only=%b last=%b",
                         m_tdata[CHAR_W-1:0], m_tdata[CHAR_W+TEXT_LEN_W-1:CHAR_W],
                         m_tdata[OUT_DATA_W-1], m_tuser, m_tlast);
            end
        end
    endfunction

    // result side: check each transfer, then pick next ready
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            check_beat();
        end
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    task automatic send_item(input logic [31:0] value, input logic [ROOM_W-1:0] room);
        predict_text(value, room);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tdata <= S_DATA_W'({room, value});
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        items_sent++;
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (expected_text.size() != 0) begin
            @(posedge aclk);
        end
        @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] index, input logic [CFG_DATA_W-1:0] data);
        cfg_index <= index;
        cfg_data <= data;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        case (index)
            CFG_RADIX: begin
                radix_setting = data[RADIX_W-1:0];
            end
            CFG_MIN_WIDTH: begin
                width_setting = data[WIDTH_W-1:0];
            end
            CFG_PAD_CHAR: begin
                pad_setting = data;
            end
            default: begin
            end
        endcase
        config_writes++;
    endtask

    task automatic apply_config(input logic [7:0] radix_data, input logic [7:0] width_data,
                                input logic [7:0] pad_data, input logic with_unused);
        wait_drained();
        write_reg(CFG_RADIX, radix_data);
        write_reg(CFG_MIN_WIDTH, width_data);
        write_reg(CFG_PAD_CHAR, pad_data);
        if (with_unused) begin
            write_reg(CFG_UNUSED, 8'($urandom_range(0, 255)));
        end
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 11))
            0: begin
                return 32'h8000_0000;
            end
            1: begin
                return 32'h7FFF_FFFF;
            end
            2: begin
                return 32'h0;
            end
            3: begin
                return 32'hFFFF_FFFF;
            end
            4, 5: begin
                return 32'($urandom_range(0, 100));
            end
            6: begin
                return -32'($urandom_range(1, 100));
            end
            default: begin
                return $urandom();
            end
        endcase
    endfunction

    function automatic logic [ROOM_W-1:0] pick_room(input int unsigned len);
        case ($urandom_range(0, 7))
            0: begin
                return '0;
            end
            1: begin
                return ROOM_W'(len);
            end
            2: begin
                return ROOM_W'(len + 1);
            end
            3: begin
                return ROOM_W'($urandom_range(0, 255));
            end
            default: begin
                return ROOM_W'($urandom_range(len + 1, 255));
            end
        endcase
    endfunction

    task automatic test_defaults_after_reset();
        send_idle_pct = 23;
        recv_idle_pct = 49;
        send_item(32'h0, 8'hFF);
        send_item(32'h7FFF_FFFF, 8'hFF);
        send_item(32'h8000_0000, 8'hFF);
        // room exactly text plus terminator, then one short
        send_item(32'hFFFF_FFFF, 8'd3);
        send_item(32'd12345, 8'd5);
        send_item(32'd7, 8'd0);
    endtask

    task automatic test_directed_settings();
        apply_config(8'd2, 8'd0, 8'h00, 1'b0);
        send_item(32'h8000_0000, 8'hFF);
        send_item(32'hFFFF_FFFF, 8'hFF);
        send_item(32'h7FFF_FFFF, 8'hFF);
        // upper data bits dropped: radix 63 clamps to 36, width 63
        apply_config(8'hFF, 8'hFF, 8'h2A, 1'b0);
        send_item(32'hFFFF_FFFF, 8'hFF);
        send_item(32'h0, 8'hFF);
        send_item(32'h7FFF_FFFF, 8'd64);
        send_item(-32'd5, 8'd64);
        apply_config(8'd0, 8'd8, 8'hFF, 1'b0);
        send_item(32'd5, 8'hFF);
        send_item(-32'd5, 8'hFF);
        apply_config(8'd1, 8'd0, 8'h30, 1'b0);
        send_item(32'h0, 8'hFF);
        apply_config(8'd37, 8'd3, 8'h00, 1'b0);
        send_item(32'd35, 8'hFF);
        send_item(-32'd36, 8'hFF);
        // write to the unused index must leave the registers alone
        apply_config(8'd16, 8'd0, 8'h00, 1'b1);
        send_item(32'hDEAD_BEEF, 8'hFF);
        send_item(32'h0000_ABCD, 8'hFF);
    endtask

    task automatic test_random_mix(input int sender_pct, input int receiver_pct, input int count);
        int done;
        int n;
        logic [7:0] radix_data;
        logic [7:0] width_data;
        logic [7:0] pad_data;
        logic [31:0] value;
        send_idle_pct = sender_pct;
        recv_idle_pct = receiver_pct;
        done = 0;
        while (done < count) begin
            radix_data = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255))
                                                     : 8'($urandom_range(2, 36));
            case ($urandom_range(0, 5))
                0: begin
                    width_data = 8'd0;
                end
                1: begin
                    width_data = 8'($urandom_range(0, 255));
                end
                default: begin
                    width_data = 8'($urandom_range(0, 12));
                end
            endcase
            pad_data = $urandom_range(0, 1) ? CHAR_NUL : 8'($urandom_range(1, 255));
            apply_config(radix_data, width_data, pad_data, $urandom_range(0, 3) == 0);
            for (n = $urandom_range(15, 30); n > 0 && done < count; n--) begin
                value = pick_value();
                send_item(value, pick_room(text_length(value)));
                done++;
            end
        end
        wait_drained();
    endtask

    task automatic test_output_backpressure();
        int n;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        apply_config(8'd16, 8'd30, 8'h2E, 1'b0);
        hold_left = HOLD_CYCLES;
        for (n = 0; n < 8; n++) begin
            send_item($urandom(), 8'hFF);
        end
        wait_drained();
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_defaults_after_reset();
        test_directed_settings();
        test_random_mix(23, 49, 95);
        test_random_mix(49, 23, 95);
        test_random_mix(0, 0, 95);
        test_output_backpressure();
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);
        $display("covered %0d items, %0d result transfers (%0d length-only), %0d register writes",
                 items_sent, beats_checked, length_only_seen, config_writes);
        $display("idling mixes: sender-heavy, receiver-heavy, none; one long receiver hold");
        if (error_count == 0 && expected_text.size() == 0) begin
            $display("integer_to_text_radix regression: pass");
        end else begin
            $display("integer_to_text_radix regression: fail");
        end
        $finish;
    end

endmodule

>>> filelist.f
+incdir+sv
sv/itr_pkg.sv
sv/itr_ctrl.sv
sv/itr_datapath.sv
sv/integer_to_text_radix.sv
sv/itr_checker.sv
verif/tb_top.sv
